FILE: rtl/core/ehi_pkg.sv
// ehi_pkg: shared constants, codes and controller/datapath interface types
// for the extendible hash insert block. No dependencies.

package ehi_pkg;

    localparam int MAX_DEPTH_DEF    = 10;
    localparam int BUCKET_SLOTS_DEF = 8;
    localparam int KEY_WIDTH_DEF    = 32;

    localparam int CAP_W        = 4;
    localparam int STATUS_W     = 2;
    localparam int DIR_INDEX_W  = 10;
    localparam int BUCKET_NUM_W = 10;
    localparam int DEPTH_OUT_W  = 4;
    localparam int SPLIT_OUT_W  = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_BKT,
        S_SCAN,
        S_DBL_RD,
        S_DBL_W0,
        S_DBL_W1,
        S_SPLIT,
        S_DIRW,
        S_MOVE0,
        S_MOVE,
        S_FILLB,
        S_FILLN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    key_load;
        logic    look_rd;
        logic    bkt_rd;
        logic    scan_next;
        logic    insert;
        logic    status_load;
        status_t status;
        logic    dbl_start;
        logic    dbl_rd;
        logic    dbl_w0;
        logic    dbl_w1;
        logic    gd_inc;
        logic    split_init;
        logic    dirw;
        logic    move_start;
        logic    move_step;
        logic    fill_b;
        logic    fill_n;
        logic    split_inc;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic dup;
        logic scan_last;
        logic has_room;
        logic ovf;
        logic need_dbl;
        logic dbl_last;
        logic dirw_last;
        logic out_busy;
    } stat_t;

endpackage

FILE: rtl/core/ehi_ctrl.sv
// ehi_ctrl: sequencer for lookup, duplicate scan, insert, directory doubling,
// bucket split and key redistribution. Depends on ehi_pkg.

module ehi_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ehi_pkg::stat_t stat,
    output ehi_pkg::cmd_t  cmd
);
    import ehi_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_INSERTED;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.key_load = 1'b1;
                    state_next   = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.look_rd = 1'b1;
                state_next  = S_BKT;
            end
            S_BKT: begin
                cmd.bkt_rd = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (stat.dup) begin
                    cmd.status_load = 1'b1;
                    cmd.status      = ST_DUPLICATE;
                    state_next      = S_DONE;
                end else if (!stat.scan_last) begin
                    cmd.scan_next = 1'b1;
                end else if (stat.has_room) begin
                    cmd.insert      = 1'b1;
                    cmd.status_load = 1'b1;
                    cmd.status      = ST_INSERTED;
                    state_next      = S_DONE;
                end else if (stat.ovf) begin
                    cmd.status_load = 1'b1;
                    cmd.status      = ST_OVERFLOW;
                    state_next      = S_DONE;
                end else if (stat.need_dbl) begin
                    cmd.dbl_start = 1'b1;
                    state_next    = S_DBL_RD;
                end else begin
                    state_next = S_SPLIT;
                end
            end
            S_DBL_RD: begin
                cmd.dbl_rd = 1'b1;
                state_next = S_DBL_W0;
            end
            S_DBL_W0: begin
                cmd.dbl_w0 = 1'b1;
                state_next = S_DBL_W1;
            end
            S_DBL_W1: begin
                cmd.dbl_w1 = 1'b1;
                if (stat.dbl_last) begin
                    cmd.gd_inc = 1'b1;
                    state_next = S_SPLIT;
                end else begin
                    state_next = S_DBL_W0;
                end
            end
            S_SPLIT: begin
                cmd.split_init = 1'b1;
                state_next     = S_DIRW;
            end
            S_DIRW: begin
                cmd.dirw = 1'b1;
                if (stat.dirw_last) begin
                    state_next = S_MOVE0;
                end
            end
            S_MOVE0: begin
                cmd.move_start = 1'b1;
                state_next     = S_MOVE;
            end
            S_MOVE: begin
                cmd.move_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_FILLB;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_FILLB: begin
                cmd.fill_b = 1'b1;
                state_next = S_FILLN;
            end
            S_FILLN: begin
                cmd.fill_n    = 1'b1;
                cmd.split_inc = 1'b1;
                state_next    = S_LOOK;
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/ehi_datapath.sv
// ehi_datapath: directory, bucket fill/depth and key memories, table state,
// capacity register and the output register. Depends on ehi_pkg.

module ehi_datapath #(
    parameter int MAX_DEPTH    = ehi_pkg::MAX_DEPTH_DEF,
    parameter int BUCKET_SLOTS = ehi_pkg::BUCKET_SLOTS_DEF,
    parameter int KEY_WIDTH    = ehi_pkg::KEY_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [ehi_pkg::CAP_W-1:0]         cfg_data,
    input  logic [KEY_WIDTH-1:0]              s_key,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic [ehi_pkg::STATUS_W-1:0]      m_status,
    output logic [ehi_pkg::DIR_INDEX_W-1:0]   m_dir_index,
    output logic [ehi_pkg::BUCKET_NUM_W-1:0]  m_bucket_number,
    output logic [ehi_pkg::DEPTH_OUT_W-1:0]   m_global_depth_now,
    output logic [ehi_pkg::SPLIT_OUT_W-1:0]   m_split_count,
    input  ehi_pkg::cmd_t                     cmd,
    output ehi_pkg::stat_t                    stat
);
    import ehi_pkg::*;

    localparam int DIR_SIZE = 1 << MAX_DEPTH;
    localparam int FW       = $clog2(BUCKET_SLOTS + 1);
    localparam int GDW      = $clog2(MAX_DEPTH + 1);
    localparam int BIUW     = MAX_DEPTH + 1;
    localparam int KAW      = $clog2(DIR_SIZE * BUCKET_SLOTS);
    localparam int KXW      = (KEY_WIDTH > MAX_DEPTH) ? KEY_WIDTH : MAX_DEPTH;
    localparam int CW       = (FW > CAP_W) ? FW : CAP_W;

    function automatic logic [MAX_DEPTH-1:0] rev_low(input logic [KXW-1:0] k,
                                                     input logic [GDW-1:0] d);
        logic [MAX_DEPTH-1:0] r;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            r[MAX_DEPTH-1-i] = k[i];
        end
        return r >> (GDW'(MAX_DEPTH) - d);
    endfunction

    function automatic logic [KAW-1:0] kaddr(input logic [MAX_DEPTH-1:0] bn,
                                             input logic [FW-1:0] slot);
        return KAW'(bn) * KAW'(BUCKET_SLOTS) + KAW'(slot);
    endfunction

    logic [MAX_DEPTH-1:0] dir_mem   [DIR_SIZE];
    logic [FW-1:0]        fill_mem  [DIR_SIZE];
    logic [GDW-1:0]       depth_mem [DIR_SIZE];
    logic [KEY_WIDTH-1:0] key_mem   [DIR_SIZE*BUCKET_SLOTS];

    logic [MAX_DEPTH-1:0] dir_q_reg;
    logic                 dir_zero_reg;
    logic [FW-1:0]        fill_q_reg;
    logic                 fill_zero_reg;
    logic [GDW-1:0]       depth_q_reg;
    logic                 depth_zero_reg;
    logic [KEY_WIDTH-1:0] key_q_reg;
    logic                 dir0_vld_reg;
    logic                 fill0_vld_reg;
    logic                 depth0_vld_reg;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [GDW-1:0]       gd_reg;
    logic [BIUW-1:0]      biu_reg;
    logic [CAP_W-1:0]     cap_reg;
    logic [MAX_DEPTH-1:0] addr_reg;
    logic [MAX_DEPTH-1:0] b_reg;
    logic [MAX_DEPTH-1:0] nb_reg;
    logic [FW-1:0]        idx_reg;
    logic [FW-1:0]        keep_reg;
    logic [FW-1:0]        ncnt_reg;
    logic [MAX_DEPTH-1:0] dptr_reg;
    logic [MAX_DEPTH-1:0] dend_reg;
    logic [GDW-1:0]       splits_reg;
    status_t              status_reg;
    logic                 m_valid_reg;
    status_t              m_status_reg;
    logic [DIR_INDEX_W-1:0]  m_dir_index_reg;
    logic [BUCKET_NUM_W-1:0] m_bucket_reg;
    logic [DEPTH_OUT_W-1:0]  m_gd_reg;
    logic [SPLIT_OUT_W-1:0]  m_splits_reg;

    logic [MAX_DEPTH-1:0] dir_rd;
    logic [FW-1:0]        fill_rd;
    logic [GDW-1:0]       depth_rd;
    logic [KXW-1:0]       key_x;
    logic [KXW-1:0]       kq_shift;
    logic [MAX_DEPTH-1:0] look_addr;
    logic [FW:0]          idx_nx;
    logic [CW-1:0]        cap_x;
    logic [CW-1:0]        cap_eff;
    logic [GDW-1:0]       span;
    logic [MAX_DEPTH-1:0] prefix;
    logic [BIUW-1:0]      start_x;
    logic [BIUW-1:0]      span_mask;
    logic                 mv_bit;
    logic                 dbl_rd_next;

    logic                 dir_re;
    logic [MAX_DEPTH-1:0] dir_raddr;
    logic                 dir_we;
    logic [MAX_DEPTH-1:0] dir_waddr;
    logic [MAX_DEPTH-1:0] dir_wdata;
    logic                 key_re;
    logic [KAW-1:0]       key_raddr;
    logic                 key_we;
    logic [KAW-1:0]       key_waddr;
    logic [KEY_WIDTH-1:0] key_wdata;
    logic                 fill_we;
    logic [MAX_DEPTH-1:0] fill_waddr;
    logic [FW-1:0]        fill_wdata;
    logic                 depth_we;
    logic [MAX_DEPTH-1:0] depth_waddr;

    assign dir_rd    = dir_zero_reg ? '0 : dir_q_reg;
    assign fill_rd   = fill_zero_reg ? '0 : fill_q_reg;
    assign depth_rd  = depth_zero_reg ? '0 : depth_q_reg;
    assign key_x     = KXW'(key_reg);
    assign look_addr = rev_low(key_x, gd_reg);
    assign idx_nx    = {1'b0, idx_reg} + (FW+1)'(1);
    assign kq_shift  = KXW'(key_q_reg) >> depth_rd;
    assign mv_bit    = kq_shift[0];

    assign cap_x   = CW'(cap_reg);
    assign cap_eff = (cap_x == '0) ? CW'(1) :
                     ((cap_x > CW'(BUCKET_SLOTS)) ? CW'(BUCKET_SLOTS) : cap_x);

    assign span      = gd_reg - depth_rd - GDW'(1);
    assign prefix    = rev_low(key_x, depth_rd);
    assign start_x   = ((BIUW'(prefix) << 1) | BIUW'(1)) << span;
    assign span_mask = (BIUW'(1) << span) - BIUW'(1);

    assign stat.dup       = (idx_reg < fill_rd) && (key_q_reg == key_reg);
    assign stat.scan_last = idx_nx >= {1'b0, fill_rd};
    assign stat.has_room  = CW'(fill_rd) < cap_eff;
    assign stat.need_dbl  = depth_rd >= gd_reg;
    assign stat.ovf       = (depth_rd >= GDW'(MAX_DEPTH)) || (biu_reg >= BIUW'(DIR_SIZE)) ||
                            ((depth_rd >= gd_reg) && (gd_reg >= GDW'(MAX_DEPTH)));
    assign stat.dbl_last  = dptr_reg == '0;
    assign stat.dirw_last = dptr_reg == dend_reg;
    assign stat.out_busy  = m_valid_reg && !m_ready;

    assign dbl_rd_next = cmd.dbl_w1 && (dptr_reg != '0);

    always_comb begin
        dir_re    = cmd.look_rd || cmd.dbl_rd || dbl_rd_next;
        dir_raddr = dptr_reg;
        if (cmd.look_rd) begin
            dir_raddr = look_addr;
        end else if (dbl_rd_next) begin
            dir_raddr = dptr_reg - MAX_DEPTH'(1);
        end
        dir_we    = cmd.dbl_w0 || cmd.dbl_w1 || cmd.dirw;
        dir_waddr = dptr_reg;
        dir_wdata = dir_rd;
        if (cmd.dbl_w0) begin
            dir_waddr = MAX_DEPTH'({dptr_reg, 1'b0});
        end else if (cmd.dbl_w1) begin
            dir_waddr = MAX_DEPTH'({dptr_reg, 1'b1});
        end else begin
            dir_wdata = nb_reg;
        end

        key_re    = cmd.bkt_rd || cmd.move_start || cmd.scan_next;
        key_raddr = kaddr(b_reg, FW'(idx_nx));
        if (cmd.bkt_rd) begin
            key_raddr = kaddr(dir_rd, '0);
        end else if (cmd.move_start) begin
            key_raddr = kaddr(b_reg, '0);
        end
        key_we    = cmd.insert || cmd.move_step;
        key_waddr = kaddr(b_reg, fill_rd);
        key_wdata = key_reg;
        if (cmd.move_step) begin
            key_wdata = key_q_reg;
            key_waddr = mv_bit ? kaddr(nb_reg, ncnt_reg) : kaddr(b_reg, keep_reg);
        end

        fill_we    = cmd.insert || cmd.fill_b || cmd.fill_n;
        fill_waddr = b_reg;
        fill_wdata = fill_rd + FW'(1);
        if (cmd.fill_b) begin
            fill_wdata = keep_reg;
        end else if (cmd.fill_n) begin
            fill_waddr = nb_reg;
            fill_wdata = ncnt_reg;
        end

        depth_we    = cmd.split_init || cmd.move_start;
        depth_waddr = cmd.move_start ? nb_reg : b_reg;
    end

    always_ff @(posedge aclk) begin
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (dir_re) begin
            dir_q_reg    <= dir_mem[dir_raddr];
            dir_zero_reg <= (dir_raddr == '0) && !dir0_vld_reg;
        end
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (key_re) begin
            key_q_reg <= key_mem[key_raddr];
        end
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (depth_we) begin
            depth_mem[depth_waddr] <= depth_rd + GDW'(1);
        end
        if (cmd.bkt_rd) begin
            fill_q_reg     <= fill_mem[dir_rd];
            fill_zero_reg  <= (dir_rd == '0) && !fill0_vld_reg;
            depth_q_reg    <= depth_mem[dir_rd];
            depth_zero_reg <= (dir_rd == '0) && !depth0_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir0_vld_reg   <= 1'b0;
            fill0_vld_reg  <= 1'b0;
            depth0_vld_reg <= 1'b0;
            gd_reg         <= '0;
            biu_reg        <= BIUW'(1);
            cap_reg        <= CAP_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            if (dir_we && (dir_waddr == '0)) begin
                dir0_vld_reg <= 1'b1;
            end
            if (fill_we && (fill_waddr == '0)) begin
                fill0_vld_reg <= 1'b1;
            end
            if (depth_we && (depth_waddr == '0)) begin
                depth0_vld_reg <= 1'b1;
            end
            if (cmd.gd_inc) begin
                gd_reg <= gd_reg + GDW'(1);
            end
            if (cmd.split_init) begin
                biu_reg <= biu_reg + BIUW'(1);
            end
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.key_load) begin
            key_reg    <= s_key;
            splits_reg <= '0;
        end
        if (cmd.split_inc) begin
            splits_reg <= splits_reg + GDW'(1);
        end
        if (cmd.look_rd) begin
            addr_reg <= look_addr;
        end
        if (cmd.bkt_rd) begin
            b_reg   <= dir_rd;
            idx_reg <= '0;
        end
        if (cmd.move_start) begin
            idx_reg  <= '0;
            keep_reg <= '0;
            ncnt_reg <= '0;
        end
        if (cmd.scan_next) begin
            idx_reg <= FW'(idx_nx);
        end
        if (cmd.move_step) begin
            if (mv_bit) begin
                ncnt_reg <= ncnt_reg + FW'(1);
            end else begin
                keep_reg <= keep_reg + FW'(1);
            end
        end
        if (cmd.status_load) begin
            status_reg <= cmd.status;
        end
        if (cmd.dbl_start) begin
            dptr_reg <= MAX_DEPTH'((BIUW'(1) << gd_reg) - BIUW'(1));
        end
        if (dbl_rd_next) begin
            dptr_reg <= dptr_reg - MAX_DEPTH'(1);
        end
        if (cmd.split_init) begin
            nb_reg   <= MAX_DEPTH'(biu_reg);
            dptr_reg <= MAX_DEPTH'(start_x);
            dend_reg <= MAX_DEPTH'(start_x | span_mask);
        end
        if (cmd.dirw) begin
            dptr_reg <= dptr_reg + MAX_DEPTH'(1);
        end
        if (cmd.out_load) begin
            m_status_reg    <= status_reg;
            m_dir_index_reg <= DIR_INDEX_W'(addr_reg);
            m_bucket_reg    <= BUCKET_NUM_W'(b_reg);
            m_gd_reg        <= DEPTH_OUT_W'(gd_reg);
            m_splits_reg    <= SPLIT_OUT_W'(splits_reg);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_dir_index        = m_dir_index_reg;
    assign m_bucket_number    = m_bucket_reg;
    assign m_global_depth_now = m_gd_reg;
    assign m_split_count      = m_splits_reg;

endmodule

FILE: rtl/core/extendible_hash_insert.sv
// extendible_hash_insert: top level, one sequencer and one datapath.
// Depends on ehi_pkg, ehi_ctrl and ehi_datapath.
//
// Usage: each word on the s_ channel (s_key) is inserted into the hash table;
// one word per key comes back on the m_ channel with status (inserted,
// duplicate, overflow), directory index, bucket number, global depth and the
// number of splits. cfg_data sets the bucket capacity (reset value 4); write
// it only while no key is in flight. cfg_ready is always high.
// The bucket is scanned one stored key per cycle; the next key is taken in
// the cycle after the result is loaded. Each split doubles the directory
// when needed, writes the directory entries of the new bucket and moves
// the keys of the old bucket, then the lookup repeats.
// One key is worked on at a time. The result sits in an output register, so
// a new key is taken while m_valid waits on m_ready; the next result waits
// until that register is free.
// Reset (synchronous, aresetn low) empties the table: bucket zero, depth
// zero, capacity 4. No clearing pass is needed.

module extendible_hash_insert #(
    parameter int MAX_DEPTH    = ehi_pkg::MAX_DEPTH_DEF,
    parameter int BUCKET_SLOTS = ehi_pkg::BUCKET_SLOTS_DEF,
    parameter int KEY_WIDTH    = ehi_pkg::KEY_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ehi_pkg::CAP_W-1:0]         cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [KEY_WIDTH-1:0]              s_key,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ehi_pkg::STATUS_W-1:0]      m_status,
    output logic [ehi_pkg::DIR_INDEX_W-1:0]   m_dir_index,
    output logic [ehi_pkg::BUCKET_NUM_W-1:0]  m_bucket_number,
    output logic [ehi_pkg::DEPTH_OUT_W-1:0]   m_global_depth_now,
    output logic [ehi_pkg::SPLIT_OUT_W-1:0]   m_split_count
);
    import ehi_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    ehi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ehi_datapath #(
        .MAX_DEPTH    (MAX_DEPTH),
        .BUCKET_SLOTS (BUCKET_SLOTS),
        .KEY_WIDTH    (KEY_WIDTH)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_data           (cfg_data),
        .s_key              (s_key),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_status           (m_status),
        .m_dir_index        (m_dir_index),
        .m_bucket_number    (m_bucket_number),
        .m_global_depth_now (m_global_depth_now),
        .m_split_count      (m_split_count),
        .cmd                (cmd),
        .stat               (stat)
    );

endmodule

FILE: rtl/core/ehi_checker.sv
// ehi_props: port-level checks on the result channel of the top level,
// attached by bind. Depends on ehi_pkg.

module ehi_props (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [ehi_pkg::STATUS_W-1:0]      m_status,
    input logic [ehi_pkg::DIR_INDEX_W-1:0]   m_dir_index,
    input logic [ehi_pkg::DEPTH_OUT_W-1:0]   m_global_depth_now,
    input logic [ehi_pkg::SPLIT_OUT_W-1:0]   m_split_count
);
    import ehi_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_dir_index))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_INSERTED) || (m_status == ST_DUPLICATE) ||
                    (m_status == ST_OVERFLOW))
        else $error("unknown status code");

    a_splits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_split_count <= m_global_depth_now)
        else $error("more splits than directory depth");

    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_dir_index >> m_global_depth_now) == '0)
        else $error("directory index beyond directory size");

endmodule

bind extendible_hash_insert ehi_props u_ehi_props (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_status           (m_status),
    .m_dir_index        (m_dir_index),
    .m_global_depth_now (m_global_depth_now),
    .m_split_count      (m_split_count)
);

FILE: verif/ehi_checker.sv
// ehi_checker: watches the cfg, s_ and m_ channels of extendible_hash_insert,
// keeps its own copy of the hash table and compares every result word.
// Depends on ehi_pkg.

module ehi_checker
    import ehi_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CAP_W-1:0]         cfg_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [31:0]              s_key,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [STATUS_W-1:0]      m_status,
    input  logic [DIR_INDEX_W-1:0]   m_dir_index,
    input  logic [BUCKET_NUM_W-1:0]  m_bucket_number,
    input  logic [DEPTH_OUT_W-1:0]   m_global_depth_now,
    input  logic [SPLIT_OUT_W-1:0]   m_split_count,
    output int                       fail_count,
    output int                       pending,
    output int                       checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH_MAX = MAX_DEPTH_DEF;
    localparam int SLOTS     = BUCKET_SLOTS_DEF;
    localparam int DIR_N     = 1 << DEPTH_MAX;

    typedef struct packed {
        status_t                 st;
        logic [DIR_INDEX_W-1:0]  idx;
        logic [BUCKET_NUM_W-1:0] bkt;
        logic [DEPTH_OUT_W-1:0]  gd;
        logic [SPLIT_OUT_W-1:0]  splits;
    } insert_result_t;

    int             dir_map [DIR_N];
    logic [31:0]    key_mem [DIR_N*SLOTS];
    int             fill    [DIR_N];
    int             ldepth  [DIR_N];
    int             gdepth;
    int             used;
    int             capacity;
    insert_result_t result_q[$];

    function automatic int rev_index(input logic [31:0] k, input int d);
        int r;
        r = 0;
        for (int i = 0; i < d; i++) r = (r << 1) | k[i];
        return r & (DIR_N - 1);
    endfunction

    function automatic bit split_bucket(input int b);
        int          ld, nb, prefix, span, lo, hi, n, keep, a, v;
        logic [31:0] old [SLOTS];
        ld = ldepth[b];
        if (ld >= DEPTH_MAX || used >= DIR_N) return 0;
        if (ld >= gdepth) begin
            if (gdepth >= DEPTH_MAX) return 0;
            for (int i = (1 << gdepth) - 1; i >= 0; i--) begin
                v = dir_map[i];
                dir_map[2*i]   = v;
                dir_map[2*i+1] = v;
            end
            gdepth++;
        end
        nb = used;
        used++;
        prefix = rev_index(key_mem[b*SLOTS], ld);
        span = gdepth - ld - 1;
        lo = ((prefix << 1) | 1) << span;
        hi = lo | ((1 << span) - 1);
        for (int i = lo; i <= hi && i < DIR_N; i++) dir_map[i] = nb;
        ldepth[b]  = ld + 1;
        ldepth[nb] = ld + 1;
        n = fill[b];
        for (int i = 0; i < n; i++) old[i] = key_mem[b*SLOTS+i];
        keep = 0;
        fill[nb] = 0;
        for (int i = 0; i < n; i++) begin
            a = rev_index(old[i], gdepth);
            if (a >= lo && a <= hi) begin
                key_mem[nb*SLOTS+fill[nb]] = old[i];
                fill[nb]++;
            end else begin
                key_mem[b*SLOTS+keep] = old[i];
                keep++;
            end
        end
        fill[b] = keep;
        return 1;
    endfunction

    function automatic insert_result_t insert_key(input logic [31:0] k);
        insert_result_t r;
        int             cap, addr, b, n, splits;
        bit             dup;
        cap = (capacity < 1) ? 1 : (capacity > SLOTS) ? SLOTS : capacity;
        splits = 0;
        forever begin
            addr = rev_index(k, gdepth);
            b = dir_map[addr];
            n = fill[b];
            dup = 0;
            for (int i = 0; i < n; i++) if (key_mem[b*SLOTS+i] == k) dup = 1;
            if (dup) begin
                r.st = ST_DUPLICATE;
                break;
            end
            if (n < cap) begin
                key_mem[b*SLOTS+n] = k;
                fill[b] = n + 1;
                r.st = ST_INSERTED;
                break;
            end
            if (!split_bucket(b)) begin
                r.st = ST_OVERFLOW;
                break;
            end
            splits++;
        end
        r.idx    = addr[DIR_INDEX_W-1:0];
        r.bkt    = b[BUCKET_NUM_W-1:0];
        r.gd     = gdepth[DEPTH_OUT_W-1:0];
        r.splits = splits[SPLIT_OUT_W-1:0];
        return r;
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    always @(posedge aclk) begin
        insert_result_t exp_r;
        if (!aresetn) begin
            for (int i = 0; i < DIR_N; i++) begin
                dir_map[i] = 0;
                fill[i]    = 0;
                ldepth[i]  = 0;
            end
            gdepth   = 0;
            used     = 1;
            capacity = CAP_RESET;
            result_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) capacity = cfg_data;
            if (s_valid && s_ready) result_q.push_back(insert_key(s_key));
            if (m_valid && m_ready) begin
                checked++;
                if (result_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result word with nothing expected, status %0d bucket %0d",
                             $time, m_status, m_bucket_number);
                end else begin
                    exp_r = result_q.pop_front();
                    if (m_status !== exp_r.st) begin
                        fail_count++;
                        $display("%0t: status expected %0d got %0d", $time, exp_r.st, m_status);
                    end
                    if (m_dir_index !== exp_r.idx) begin
                        fail_count++;
                        $display("%0t: dir_index expected %0d got %0d",
                                 $time, exp_r.idx, m_dir_index);
                    end
                    if (m_bucket_number !== exp_r.bkt) begin
                        fail_count++;
                        $display("%0t: bucket_number expected %0d got %0d",
                                 $time, exp_r.bkt, m_bucket_number);
                    end
                    if (m_global_depth_now !== exp_r.gd) begin
                        fail_count++;
                        $display("%0t: global_depth_now expected %0d got %0d",
                                 $time, exp_r.gd, m_global_depth_now);
                    end
                    if (m_split_count !== exp_r.splits) begin
                        fail_count++;
                        $display("%0t: split_count expected %0d got %0d",
                                 $time, exp_r.splits, m_split_count);
                    end
                end
            end
        end
        pending <= result_q.size();
    end

endmodule

FILE: verif/tb_extendible_hash_insert.sv
// tb_extendible_hash_insert: clock, reset, key and capacity stimulus with
// random idling on both channels. Depends on ehi_pkg, ehi_checker and the RTL.

module tb_extendible_hash_insert;
    import ehi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CAP_W-1:0]        cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [31:0]             s_key;
    logic                    m_valid;
    logic                    m_ready;
    logic [STATUS_W-1:0]     m_status;
    logic [DIR_INDEX_W-1:0]  m_dir_index;
    logic [BUCKET_NUM_W-1:0] m_bucket_number;
    logic [DEPTH_OUT_W-1:0]  m_global_depth_now;
    logic [SPLIT_OUT_W-1:0]  m_split_count;

    int          fail_count;
    int          pending;
    int          checked;
    int          idle_s;
    int          idle_m;
    int          keys_sent;
    int          cycles;
    bit          hold_req;
    logic [31:0] seen_q[$];

    extendible_hash_insert u_top (.*);

    ehi_checker u_chk (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                for (int i = 0; i < 400; i++) begin
                    m_ready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_ready <= ($urandom_range(99) >= idle_m);
        end
    end

    task automatic send_key(input logic [31:0] k);
        while ($urandom_range(99) < idle_s) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_key   <= k;
        do @(posedge aclk); while (!s_ready);
        keys_sent++;
        seen_q.push_back(k);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 25 && seen_q.size() > 0) return seen_q[$urandom_range(seen_q.size() - 1)];
        if (sel < 60) return (32'($urandom) << 12) | 32'($urandom_range(15));
        return $urandom;
    endfunction

    initial begin
        logic [31:0]      directed_keys[$];
        logic [CAP_W-1:0] phase_cap[3];
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_key     = '0;
        hold_req  = 0;
        idle_s    = 0;
        idle_m    = 0;
        keys_sent = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // default capacity: edges, duplicate, splits from shared low bits
        directed_keys = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 32'h2,
                          32'h3, 32'h4, 32'h5, 32'hFFFF_FFFF};
        foreach (directed_keys[i]) send_key(directed_keys[i]);
        // capacity zero acts as one: same low ten bits drive depth to the limit
        write_capacity(4'd0);
        directed_keys = '{32'h400, 32'h800, 32'hC00, 32'h400};
        foreach (directed_keys[i]) send_key(directed_keys[i]);
        // capacity above slot count acts as eight
        write_capacity(4'd15);
        directed_keys = '{32'h5555_AAAA, 32'hAAAA_5555, 32'h1000, 32'h2000, 32'h3000,
                          32'h7FFF_FFFF};
        foreach (directed_keys[i]) send_key(directed_keys[i]);

        phase_cap = '{4'd3, 4'd8, 4'd1};
        for (int ph = 0; ph < 3; ph++) begin
            write_capacity(phase_cap[ph]);
            idle_s = (ph == 0) ? 37 : (ph == 1) ? 59 : 0;
            idle_m = (ph == 0) ? 59 : (ph == 1) ? 37 : 0;
            for (int n = 0; n < 580; n++) begin
                if (ph == 0 && n == 100) hold_req = 1;
                if (ph == 1 && n == 300) wait_drained();
                send_key(pick_key());
            end
        end

        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        $display("sent %0d keys over capacities 4, 0, 15, 3, 8 and 1; checked %0d results",
                 keys_sent, checked);
        $display("mismatches: %0d", fail_count);
        if (fail_count == 0 && checked == keys_sent) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
